// File: hdl/wcg_pkg.sv
`timescale 1ns / 1ps
// wcg_pkg: shared types and constants for the work chunk grouper
// no dependencies; imported by the grouper top level and the bench

package wcg_pkg;

    localparam int INDEX_BITS = 20;
    localparam int SIZE_BITS  = 20;
    localparam int COUNT_BITS = 21;
    localparam int BYTES_BITS = 40;
    localparam int SUM_BITS   = 64;
    localparam int LIMIT_BITS = 32;
    localparam int LN_BITS    = 22;
    localparam int DIV_STEPS  = 80;

    localparam logic [31:0] LN2_Q16 = 32'd45426;

    // mode register codes
    localparam logic [2:0] MODE_COUNT  = 3'd0;
    localparam logic [2:0] MODE_LINEAR = 3'd1;
    localparam logic [2:0] MODE_SQUARE = 3'd2;
    localparam logic [2:0] MODE_CUBIC  = 3'd3;
    localparam logic [2:0] MODE_NLOGN  = 3'd4;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_PROC,
        S_T2, S_T2W,
        S_T3, S_T3W, S_T3X, S_T3Y,
        S_T4, S_T4W,
        S_ADD,
        S_C2, S_C2W,
        S_C3, S_C3W, S_C3X, S_C3Y,
        S_NL0, S_NL1, S_NL2, S_NL3, S_NL4,
        S_LNS, S_LNN, S_LNQ, S_LNR, S_LNF, S_LNE,
        S_DIV,
        S_CMP,
        S_EMIT
    } t_state;

endpackage

// File: hdl/wcg_mul.sv
`timescale 1ns / 1ps
// wcg_mul: shared 32x32 multiplier with registered product
// depends on nothing but the clock; used by the grouper sequencer

module wcg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    // product is registered: ready in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: hdl/work_chunk_grouper.sv
`timescale 1ns / 1ps
// Work chunk grouper, top level: record bookkeeping, metric sequencer and output register.
// Each accepted beat goes through the sequencer: count and linear mode add a direct term,
// square and cubic mode use the shared multiplier and n log n mode runs the Q.16 log loop
// (normalize plus 16 squarings on the shared multiplier) and the 80-step restoring divider.
// One record is in work at a time; s_tready is high only in the idle state.
// Synchronous active-low reset: mode 1, limit 1048576, no chunk open, index 0, no result.

module work_chunk_grouper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // record input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] record_size, zero padded
    input  logic        s_tuser,   // [0] pending
    input  logic        s_tlast,   // last_record
    // chunk output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [19:0] first_index, [40:20] record_count,
                                   // [80:41] byte_count, zero padded
);
    import wcg_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]  r_mode;
    logic [LIMIT_BITS-1:0] r_limit;
    logic [INDEX_BITS-1:0] r_next_idx, n_next_idx, r_idx, n_idx;
    logic [INDEX_BITS-1:0] r_open_first, n_open_first;
    logic [COUNT_BITS-1:0] r_open_count, n_open_count;
    logic [BYTES_BITS-1:0] r_open_bytes, n_open_bytes;
    logic [SUM_BITS-1:0]   r_sum, n_sum, r_term, n_term;
    logic [SUM_BITS-1:0]   r_cmp_a, n_cmp_a, r_cmp_b, n_cmp_b;
    logic r_open, n_open, r_pend, n_pend, r_last, n_last;
    logic [SIZE_BITS-1:0]  r_size, n_size;
    logic [31:0] r_hi, n_hi;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_lnx, n_lnx;
    logic [5:0]  r_e, n_e;
    logic [31:0] r_z, n_z;
    logic [LN_BITS-1:0] r_log2q, n_log2q, r_ln, n_ln;
    logic [3:0]  r_i, n_i;
    logic [79:0] r_dq, n_dq;
    logic [LN_BITS-1:0] r_rem, n_rem, r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic [INDEX_BITS-1:0] r_out_first, n_out_first;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic [BYTES_BITS-1:0] r_out_bytes, n_out_bytes;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        accept;
    logic [BYTES_BITS:0]   bytes_sum;
    logic [SUM_BITS:0]     metric_sum;
    logic [95:0]           wide;
    logic [31:0]           sq_top;
    logic [LN_BITS:0]      div_t;
    logic                  div_ge;
    logic [63:0]           q_sat;

    wcg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_bytes, r_out_count, r_out_first};

    // shared datapath pieces
    assign bytes_sum  = {1'b0, (r_open ? r_open_bytes : {BYTES_BITS{1'b0}})}
                        + {{(BYTES_BITS-SIZE_BITS+1){1'b0}}, r_size};
    assign metric_sum = {1'b0, r_sum} + {1'b0, r_term};
    assign wide       = {mul_p, 32'd0} + {32'd0, r_lo};
    assign sq_top     = mul_p[61:30];
    assign div_t      = {r_rem, r_dq[79]};
    assign div_ge     = (div_t >= {1'b0, r_den});
    assign q_sat      = (|r_dq[79:64]) ? {64{1'b1}} : r_dq[63:0];

    // multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_state)
            S_T2, S_T3: begin
                mul_a = {{(32-SIZE_BITS){1'b0}}, r_size};
                mul_b = {{(32-SIZE_BITS){1'b0}}, r_size};
            end
            S_T3W: begin
                mul_a = mul_p[31:0];
                mul_b = {{(32-SIZE_BITS){1'b0}}, r_size};
            end
            S_T3X: begin
                mul_a = r_hi;
                mul_b = {{(32-SIZE_BITS){1'b0}}, r_size};
            end
            S_T4: begin
                mul_a = {{(32-SIZE_BITS){1'b0}}, r_size};
                mul_b = {26'd0, r_ln[21:16]};
            end
            S_C2, S_C3: begin
                mul_a = r_limit;
                mul_b = r_limit;
            end
            S_C3W: begin
                mul_a = mul_p[31:0];
                mul_b = r_limit;
            end
            S_C3X: begin
                mul_a = r_hi;
                mul_b = r_limit;
            end
            S_LNQ: begin
                mul_a = r_z;
                mul_b = r_z;
            end
            S_LNF: begin
                mul_a = {{(32-LN_BITS){1'b0}}, r_log2q};
                mul_b = LN2_Q16;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state = r_state;       n_ret = r_ret;
        n_next_idx = r_next_idx; n_idx = r_idx;
        n_open_first = r_open_first; n_open_count = r_open_count;
        n_open_bytes = r_open_bytes; n_sum = r_sum; n_term = r_term;
        n_cmp_a = r_cmp_a; n_cmp_b = r_cmp_b; n_open = r_open;
        n_pend = r_pend; n_last = r_last; n_size = r_size;
        n_hi = r_hi; n_lo = r_lo; n_lnx = r_lnx; n_e = r_e; n_z = r_z;
        n_log2q = r_log2q; n_ln = r_ln; n_i = r_i;
        n_dq = r_dq; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_out_valid = r_out_valid && !m_tready;
        n_out_first = r_out_first; n_out_count = r_out_count;
        n_out_bytes = r_out_bytes;

        unique case (r_state)
            // take a record beat
            S_IDLE: begin
                if (accept) begin
                    n_size     = s_tdata[SIZE_BITS-1:0];
                    n_pend     = s_tuser;
                    n_last     = s_tlast;
                    n_idx      = r_next_idx;
                    n_next_idx = s_tlast ? {INDEX_BITS{1'b0}} : r_next_idx + 1'b1;
                    n_state    = S_PROC;
                end
            end
            // bookkeeping and term dispatch
            S_PROC: begin
                if (!r_pend) begin
                    n_state = r_open ? S_EMIT : S_IDLE;
                end else begin
                    n_open = 1'b1;
                    if (!r_open) begin
                        n_open_first = r_idx;
                        n_open_count = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                        n_sum        = {SUM_BITS{1'b0}};
                    end else if (r_open_count != {COUNT_BITS{1'b1}}) begin
                        n_open_count = r_open_count + 1'b1;
                    end
                    n_open_bytes = bytes_sum[BYTES_BITS] ? {BYTES_BITS{1'b1}}
                                                         : bytes_sum[BYTES_BITS-1:0];
                    n_term = {{(SUM_BITS-SIZE_BITS){1'b0}}, r_size};
                    n_state = S_ADD;
                    priority case (r_mode)
                        MODE_COUNT:  n_term = {{(SUM_BITS-1){1'b0}}, 1'b1};
                        MODE_SQUARE: n_state = S_T2;
                        MODE_CUBIC:  n_state = S_T3;
                        MODE_NLOGN: begin
                            if (r_size <= SIZE_BITS'(1)) begin
                                n_term = {SUM_BITS{1'b0}};
                            end else begin
                                n_lnx   = {{(64-SIZE_BITS){1'b0}}, r_size};
                                n_ret   = S_T4;
                                n_state = S_LNS;
                            end
                        end
                        default: n_state = S_ADD;
                    endcase
                end
            end
            // square term
            S_T2:  n_state = S_T2W;
            S_T2W: begin
                n_term  = mul_p;
                n_state = S_ADD;
            end
            // cube term over two partial products
            S_T3:  n_state = S_T3W;
            S_T3W: begin
                n_hi    = mul_p[63:32];
                n_state = S_T3X;
            end
            S_T3X: begin
                n_lo    = mul_p;
                n_state = S_T3Y;
            end
            S_T3Y: begin
                n_term  = wide[63:0];
                n_state = S_ADD;
            end
            // n log n term
            S_T4:  n_state = S_T4W;
            S_T4W: begin
                n_term  = mul_p;
                n_state = S_ADD;
            end
            // saturating metric add and bound dispatch
            S_ADD: begin
                n_sum   = metric_sum[SUM_BITS] ? {SUM_BITS{1'b1}} : metric_sum[SUM_BITS-1:0];
                n_cmp_a = n_sum;
                n_cmp_b = {32'd0, r_limit};
                priority case (r_mode)
                    MODE_SQUARE: n_state = S_C2;
                    MODE_CUBIC:  n_state = S_C3;
                    MODE_NLOGN:  n_state = S_NL0;
                    default:     n_state = S_CMP;
                endcase
            end
            // limit squared
            S_C2:  n_state = S_C2W;
            S_C2W: begin
                n_cmp_b = mul_p;
                n_state = S_CMP;
            end
            // limit cubed, saturating
            S_C3:  n_state = S_C3W;
            S_C3W: begin
                n_hi    = mul_p[63:32];
                n_state = S_C3X;
            end
            S_C3X: begin
                n_lo    = mul_p;
                n_state = S_C3Y;
            end
            S_C3Y: begin
                n_cmp_b = (|wide[95:64]) ? {64{1'b1}} : wide[63:0];
                n_state = S_CMP;
            end
            // n log n bound: S / ln(S / ln S)
            S_NL0: begin
                if (r_sum <= 64'd2) begin
                    n_state = S_CMP;
                end else begin
                    n_lnx   = r_sum;
                    n_ret   = S_NL1;
                    n_state = S_LNS;
                end
            end
            S_NL1, S_NL3: begin
                if (r_ln == {LN_BITS{1'b0}}) begin
                    n_state = S_CMP;
                end else begin
                    n_dq    = {r_sum, 16'd0};
                    n_den   = r_ln;
                    n_rem   = {LN_BITS{1'b0}};
                    n_cnt   = 7'd0;
                    n_ret   = (r_state == S_NL1) ? S_NL2 : S_NL4;
                    n_state = S_DIV;
                end
            end
            S_NL2: begin
                n_lnx   = q_sat;
                n_ret   = S_NL3;
                n_state = S_LNS;
            end
            S_NL4: begin
                n_cmp_a = q_sat;
                n_state = S_CMP;
            end
            // Q.16 natural log: zero check
            S_LNS: begin
                n_e = 6'd63;
                if (r_lnx == 64'd0) begin
                    n_ln    = {LN_BITS{1'b0}};
                    n_state = r_ret;
                end else begin
                    n_state = S_LNN;
                end
            end
            // normalize the leading one to bit 63
            S_LNN: begin
                if (r_lnx[63]) begin
                    n_z     = {1'b0, r_lnx[63:33]};
                    n_log2q = {r_e, 16'd0};
                    n_i     = 4'd15;
                    n_state = S_LNQ;
                end else if (r_lnx[63:56] == 8'd0) begin
                    n_lnx = {r_lnx[55:0], 8'd0};
                    n_e   = r_e - 6'd8;
                end else begin
                    n_lnx = {r_lnx[62:0], 1'b0};
                    n_e   = r_e - 6'd1;
                end
            end
            // one fraction bit per squaring
            S_LNQ: n_state = S_LNR;
            S_LNR: begin
                if (sq_top[31]) begin
                    n_z     = {1'b0, sq_top[31:1]};
                    n_log2q = r_log2q | (LN_BITS'(1) << r_i);
                end else begin
                    n_z = sq_top;
                end
                if (r_i == 4'd0) begin
                    n_state = S_LNF;
                end else begin
                    n_i     = r_i - 4'd1;
                    n_state = S_LNQ;
                end
            end
            // scale log2 by ln 2
            S_LNF: n_state = S_LNE;
            S_LNE: begin
                n_ln    = mul_p[37:16];
                n_state = r_ret;
            end
            // restoring divide, one quotient bit a cycle
            S_DIV: begin
                n_rem = div_ge ? LN_BITS'(div_t - {1'b0, r_den}) : div_t[LN_BITS-1:0];
                n_dq  = {r_dq[78:0], div_ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_STEPS-1)) begin
                    n_state = r_ret;
                end
            end
            // threshold decision
            S_CMP: begin
                n_state = ((r_cmp_a >= r_cmp_b) || r_last) ? S_EMIT : S_IDLE;
            end
            // hand the chunk to the output register
            S_EMIT: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_first = r_open_first;
                    n_out_count = r_open_count;
                    n_out_bytes = r_open_bytes;
                    n_open      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_mode      <= MODE_LINEAR;
            r_limit     <= 32'd1048576;
            r_next_idx  <= {INDEX_BITS{1'b0}};
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_next_idx  <= n_next_idx;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default:   r_limit <= r_limit;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;   r_open_first <= n_open_first;
        r_open_count <= n_open_count; r_open_bytes <= n_open_bytes;
        r_sum <= n_sum;   r_term <= n_term;
        r_cmp_a <= n_cmp_a; r_cmp_b <= n_cmp_b;
        r_pend <= n_pend; r_last <= n_last; r_size <= n_size;
        r_hi <= n_hi;     r_lo <= n_lo;
        r_lnx <= n_lnx;   r_e <= n_e; r_z <= n_z;
        r_log2q <= n_log2q; r_ln <= n_ln; r_i <= n_i;
        r_dq <= n_dq;     r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
        r_out_first <= n_out_first; r_out_count <= n_out_count;
        r_out_bytes <= n_out_bytes;
    end
endmodule

// File: hdl/wcg_chk.sv
`timescale 1ns / 1ps
// wcg_chk: port-level checks for the work chunk grouper
// depends on work_chunk_grouper; attached by the bind at the end of this file

module wcg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    // a record is worked on before the next is taken
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a chunk holds at least one record
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[40:20] != 21'd0))
        else $error("empty chunk emitted");
endmodule

bind work_chunk_grouper wcg_chk u_wcg_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for work_chunk_grouper; drives record beats, predicts each chunk
// depends on hdl/wcg_pkg.sv and hdl/work_chunk_grouper.sv

module tb;
    import wcg_pkg::*;

    localparam int  SETTLE_CYCLES = 400;
    localparam int  CYCLE_LIMIT   = 2000000;
    localparam logic [63:0] SUM_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [39:0] BYTES_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [20:0] COUNT_MAX = 21'h1F_FFFF;

    typedef struct packed {
        logic [19:0] first_index;
        logic [20:0] record_count;
        logic [39:0] byte_count;
    } chunk_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    // predictor state
    logic [2:0]  cur_mode;
    logic [31:0] cur_limit;
    logic [19:0] nxt_index;
    logic [19:0] chunk_first;
    logic [20:0] chunk_count;
    logic [39:0] chunk_bytes;
    logic [63:0] chunk_metric;
    logic        chunk_active;

    chunk_t expected_chunks[$];
    int     errors;
    int     records_sent;
    int     chunks_seen;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_req;
    int     hold_left;
    int     cycles;

    work_chunk_grouper DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? SUM_MAX : s[63:0];
    endfunction

    // natural log in q16: log2 by repeated squaring of a q30 mantissa, times ln 2
    function automatic logic [63:0] log_q16(input logic [63:0] x);
        int          msb;
        logic [63:0] z;
        logic [63:0] l2;
        if (x == 0) return 0;
        msb = 0;
        for (int b = 0; b < 64; b++) if (x[b]) msb = b;
        z  = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        l2 = 64'(msb) << 16;
        for (int b = 15; b >= 0; b--) begin
            z = (z * z) >> 30;
            if (z >= 64'h8000_0000) begin
                z = z >> 1;
                l2[b] = 1'b1;
            end
        end
        return (l2 * 64'd45426) >> 16;
    endfunction

    // floor(s * 2^16 / d), saturating
    function automatic logic [63:0] div_by_log(input logic [63:0] s, input logic [63:0] d);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = s / d;
        lo = ((s % d) << 16) / d;
        if (hi > (SUM_MAX >> 16)) return SUM_MAX;
        return add_sat(hi << 16, lo);
    endfunction

    function automatic logic [63:0] nlogn_bound(input logic [63:0] s);
        logic [63:0] lns;
        logic [63:0] q;
        logic [63:0] lnq;
        if (s <= 2) return s;
        lns = log_q16(s);
        if (lns == 0) return s;
        q   = div_by_log(s, lns);
        lnq = log_q16(q);
        if (lnq == 0) return s;
        return div_by_log(s, lnq);
    endfunction

    function automatic logic [63:0] limit_cubed(input logic [63:0] l);
        logic [127:0] c;
        c = 128'(l) * l * l;
        return (c[127:64] != 0) ? SUM_MAX : c[63:0];
    endfunction

    // advance the grouping state by one record; returns 1 when a chunk closes
    function automatic bit group_record(input logic [19:0] size, input bit pend, input bit last,
                                        output chunk_t res);
        logic [63:0] sz;
        logic [63:0] term;
        logic [40:0] bsum;
        bit          hit;
        sz = 64'(size);
        res = '0;
        if (!pend) begin
            res = '{chunk_first, chunk_count, chunk_bytes};
            hit = chunk_active;
        end else begin
            if (!chunk_active) begin
                chunk_active = 1'b1;
                chunk_first  = nxt_index;
                chunk_count  = 0;
                chunk_bytes  = 0;
                chunk_metric = 0;
            end
            if (chunk_count != COUNT_MAX) chunk_count++;
            bsum = {1'b0, chunk_bytes} + 41'(size);
            chunk_bytes = bsum[40] ? BYTES_MAX : bsum[39:0];
            case (cur_mode)
                MODE_COUNT:  term = 1;
                MODE_SQUARE: term = sz * sz;
                MODE_CUBIC:  term = sz * sz * sz;
                MODE_NLOGN:  term = (sz <= 1) ? 0 : sz * (log_q16(sz) >> 16);
                default:     term = sz;
            endcase
            chunk_metric = add_sat(chunk_metric, term);
            case (cur_mode)
                MODE_SQUARE: hit = chunk_metric >= 64'(cur_limit) * 64'(cur_limit);
                MODE_CUBIC:  hit = chunk_metric >= limit_cubed(64'(cur_limit));
                MODE_NLOGN:  hit = nlogn_bound(chunk_metric) >= 64'(cur_limit);
                default:     hit = chunk_metric >= 64'(cur_limit);
            endcase
            hit = hit || last;
            res = '{chunk_first, chunk_count, chunk_bytes};
        end
        nxt_index = last ? 20'd0 : nxt_index + 20'd1;
        if (hit) begin
            chunk_active = 1'b0;
            chunk_first  = 0;
            chunk_count  = 0;
            chunk_bytes  = 0;
            chunk_metric = 0;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        chunk_t got;
        chunk_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[19:0], m_tdata[40:20], m_tdata[80:41]};
            chunks_seen++;
            if (expected_chunks.size() == 0) begin
                report_mismatch("unexpected chunk, first_index", 64'(got.first_index), 0);
            end else begin
                want = expected_chunks.pop_front();
                if (got.first_index != want.first_index)
                    report_mismatch("first_index", 64'(got.first_index), 64'(want.first_index));
                if (got.record_count != want.record_count)
                    report_mismatch("record_count", 64'(got.record_count),
                                    64'(want.record_count));
                if (got.byte_count != want.byte_count)
                    report_mismatch("byte_count", 64'(got.byte_count), 64'(want.byte_count));
                if (m_tdata[87:81] != 0)
                    report_mismatch("tdata padding", 64'(m_tdata[87:81]), 0);
            end
        end
    end

    // receiver: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one record beat and return on the edge that accepts it
    task automatic send_record(input logic [19:0] size, input bit pend, input bit last);
        chunk_t res;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, size};
        s_tuser  <= pend;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        records_sent++;
        if (group_record(size, pend, last, res)) expected_chunks.push_back(res);
    endtask

    // stop offering and let every expected chunk come out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (addr == CFG_MODE) cur_mode = data[2:0];
        else cur_limit = data;
    endtask

    function automatic logic [19:0] rand_size();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 3));
            1: return 20'($urandom_range(0, 255));
            2: return 20'($urandom_range(0, 65535));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_limit(input logic [2:0] m);
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        case (m)
            MODE_COUNT:  return $urandom_range(0, 8);
            MODE_SQUARE: return $urandom_range(0, 3000000);
            MODE_CUBIC:  return $urandom_range(0, 3000000);
            MODE_NLOGN:  return $urandom_range(0, 20000000);
            default:     return $urandom_range(0, 4000000);
        endcase
    endfunction

    // extremes of the fields, every mode, zero and full limits, unused codes, mode switch
    task automatic test_directed();
        send_record(20'd0, 1, 0);
        send_record(20'hFFFFF, 1, 0);
        send_record(20'd5, 0, 0);
        send_record(20'd7, 0, 0);
        send_record(20'hFFFFF, 1, 1);
        send_record(20'd3, 1, 0);
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MODE, 32'(m));
            write_reg(CFG_LIMIT, 32'd0);
            send_record(20'd9, 1, 0);
            write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
            send_record(20'hFFFFF, 1, 0);
            send_record(20'd1, 1, m == 7);
        end
        // mode switched while a chunk is open keeps the running sum
        write_reg(CFG_MODE, {29'h1FFF_FFFF, MODE_LINEAR});
        write_reg(CFG_LIMIT, 32'd2000);
        send_record(20'd1500, 1, 0);
        write_reg(CFG_MODE, 32'(MODE_SQUARE));
        send_record(20'd10, 1, 0);
        send_record(20'd10, 1, 0);
        write_reg(CFG_MODE, 32'(MODE_NLOGN));
        write_reg(CFG_LIMIT, 32'd40);
        send_record(20'd2, 1, 0);
        send_record(20'd100, 1, 0);
        send_record(20'd0, 0, 1);
    endtask

    // random records per mode under the current idling mix
    task automatic test_random(input int per_mode);
        logic [2:0] m;
        for (int k = 0; k < 6; k++) begin
            m = (k == 5) ? 3'($urandom_range(5, 7)) : 3'(k);
            write_reg(CFG_MODE, {29'($urandom), m});
            write_reg(CFG_LIMIT, rand_limit(m));
            for (int n = 0; n < per_mode; n++)
                send_record(rand_size(), $urandom_range(0, 99) < 85,
                            $urandom_range(0, 99) < 5);
        end
    endtask

    // long receiver hold-off while records keep coming, then a full pause
    task automatic test_backpressure();
        write_reg(CFG_MODE, 32'(MODE_COUNT));
        write_reg(CFG_LIMIT, 32'd1);
        hold_req = 300;
        for (int n = 0; n < 20; n++) send_record(rand_size(), 1, 0);
        drain();
        for (int n = 0; n < 10; n++) send_record(rand_size(), 1, n == 9);
    endtask

    initial begin
        errors = 0;
        records_sent = 0;
        chunks_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        cycles = 0;
        cur_mode = MODE_LINEAR;
        cur_limit = 32'd1048576;
        nxt_index = 0;
        chunk_first = 0;
        chunk_count = 0;
        chunk_bytes = 0;
        chunk_metric = 0;
        chunk_active = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= 1'b0;
        i_cfg_data <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        s_tlast    <= 1'b0;
        m_tready   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(65);
        send_idle_pct = 58;
        test_random(65);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        test_random(65);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        test_random(65);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain();

        $display("covered %0d records and %0d chunks over all modes, limit extremes,",
                 records_sent, chunks_seen);
        $display("sender gaps, receiver stalls and a long output hold-off");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/wcg_pkg.sv
hdl/wcg_mul.sv
hdl/work_chunk_grouper.sv
hdl/wcg_chk.sv
verif/tb.sv
